// ===== hdl/mta_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mta_pkg;
  localparam int GROUPS = 12;
  localparam int NLAGS = 8 * GROUPS + 8;
  localparam int LAG_W = $clog2(NLAGS);
  localparam int GRP_W = $clog2(GROUPS);
  localparam logic [47:0] MAX48 = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] MIN48 = 48'h8000_0000_0000;
  localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  // saturating 48-bit signed add
  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {a[47], a} + {b[47], b};
    if (s[48] != s[47]) sat_add48 = s[48] ? MIN48 : MAX48;
    else sat_add48 = s[47:0];
  endfunction

  // saturating 64-bit signed add
  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) sat_add64 = s[64] ? MIN64 : MAX64;
    else sat_add64 = s[63:0];
  endfunction

  // base address of a group in the lag stores
  function automatic logic [LAG_W-1:0] grp_base(input logic [GRP_W-1:0] g);
    logic [LAG_W+GRP_W:0] b;
    b = (g == '0) ? '0 : ({{(LAG_W+1){1'b0}}, g} << 3) + (LAG_W+GRP_W+1)'(8);
    grp_base = b[LAG_W-1:0];
  endfunction
endpackage
`default_nettype wire

// ===== hdl/mta_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none
// shared multiplier unit: registered 32x32 signed product
// zero bins and ring slots stay within 28 signed bits, so the product never clamps
module mta_mac import mta_pkg::*; (
  input  wire logic               clk,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic         [63:0]     prod_sat_r
);
  logic signed [63:0] p;

  // signed product of bounded operands
  assign p = a * b;

  always_ff @(posedge clk) begin
    prod_sat_r <= p;
  end
endmodule
`default_nettype wire

// ===== hdl/multi_tau_autocorrelator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// push: accepted in S_IDLE; each visited group takes an entry step, a read, wait
// and accumulate pass per lag and a ring rotation, set by the single lag-store port
// and shared mac; read: through S_RD0 and S_RD1 to a registered result
// synchronous active-low reset clears all stores by a sweep over all NLAGS addresses
// (in_ready low meanwhile); afterwards in_ready rises
module multi_tau_autocorrelator import mta_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_opcode,
  input  wire logic signed [15:0] in_sample,
  input  wire logic [6:0]         in_lag_index,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [63:0]      out_product_sum,
  output logic signed [47:0]      out_delayed_sum,
  output logic signed [47:0]      out_direct_sum,
  output logic                    out_lag_valid,
  output logic [31:0]             out_sample_count,
  output logic signed [47:0]      out_total_sum,
  output logic [62:0]             out_square_sum
);
  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD0, S_RD1, S_GRP, S_LRD, S_LWAIT, S_LACC, S_ROT, S_ROTW, S_OUT
  } state_t;

  // memories: ring, product and delayed accumulators
  logic [39:0] ring_mem [NLAGS];
  logic [63:0] prod_mem [NLAGS];
  logic [47:0] dly_mem  [NLAGS];
  logic [39:0] ring_q;
  logic [63:0] prod_q;
  logic [47:0] dly_q;
  logic [LAG_W-1:0] addr;
  logic ring_we, acc_we;
  logic [39:0] ring_wd;
  logic [63:0] prod_wd;
  logic [47:0] dly_wd;

  // per-group registers
  logic [47:0] direct_r [GROUPS];
  logic [39:0] zero_r   [GROUPS];
  logic [39:0] carry_r  [GROUPS];
  logic [3:0]  head_r   [GROUPS];
  logic [4:0]  fill_r   [GROUPS];
  logic [GROUPS-1:0] parity_r;
  logic [31:0] count_r;
  logic [47:0] sum_r;
  logic [62:0] sq_r;

  state_t state_r;
  logic [LAG_W-1:0] clr_r;
  logic [GRP_W-1:0] g_r;
  logic [4:0] d_r;
  logic [39:0] zb_r;
  logic [LAG_W-1:0] rlag_r;
  logic rvalid_r;
  logic [GRP_W-1:0] rg_r;
  logic [4:0] rd_r;

  logic [63:0] mac_q;
  logic [4:0] len;
  logic [3:0] hmask, slot, newest;
  logic [LAG_W-1:0] base;
  logic [39:0] ring_hold_r;

  mta_mac u_mac (.clk(clk), .a(zb_r[31:0]), .b(ring_q[31:0]), .prod_sat_r(mac_q));

  always_comb begin
    len = (g_r == '0) ? 5'd16 : 5'd8;
    hmask = (g_r == '0) ? 4'hF : 4'h7;
    base = grp_base(g_r);
    slot = (head_r[g_r] + d_r[3:0]) & hmask;
    newest = (head_r[g_r] + hmask) & hmask;
  end

  // memory address and write data
  always_comb begin
    addr = base + LAG_W'(slot);
    ring_we = 1'b0;
    acc_we = 1'b0;
    ring_wd = (g_r == '0) ? zb_r : carry_r[g_r];
    prod_wd = sat_add64(prod_q, mac_q);
    dly_wd = sat_add48(dly_q, {{8{ring_hold_r[39]}}, ring_hold_r});
    case (state_r)
      S_CLR: begin
        addr = clr_r;
        ring_we = 1'b1;
        acc_we = 1'b1;
        ring_wd = '0;
        prod_wd = '0;
        dly_wd = '0;
      end
      S_RD0, S_RD1: addr = rlag_r;
      S_LRD: addr = base + LAG_W'(slot);
      S_LWAIT: addr = base + LAG_W'(d_r);
      S_LACC: begin
        addr = base + LAG_W'(d_r);
        acc_we = 1'b1;
      end
      S_ROT, S_ROTW: begin
        addr = base + LAG_W'(newest);
        ring_we = (state_r == S_ROTW);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[addr] <= ring_wd;
    if (acc_we) begin
      prod_mem[addr] <= prod_wd;
      dly_mem[addr] <= dly_wd;
    end
    ring_q <= ring_mem[addr];
    prod_q <= prod_mem[addr];
    dly_q <= dly_mem[addr];
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  // sequencer
  always_ff @(posedge clk) begin
    logic [16:0] dd;
    logic [47:0] sqw;
    logic [64:0] sqs;
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      parity_r <= '0;
      count_r <= '0;
      sum_r <= '0;
      sq_r <= '0;
      for (int i = 0; i < GROUPS; i++) begin
        direct_r[i] <= '0;
        zero_r[i] <= '0;
        carry_r[i] <= '0;
        head_r[i] <= '0;
        fill_r[i] <= (i == 0) ? 5'd16 : 5'd8;
      end
    end else begin
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == LAG_W'(NLAGS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          if (in_opcode == OP_READ) begin
            rvalid_r <= (in_lag_index < 7'(NLAGS));
            rlag_r <= in_lag_index[LAG_W-1:0];
            if (in_lag_index < 7'd16) begin
              rg_r <= '0;
              rd_r <= 5'(in_lag_index);
            end else begin
              dd = 17'(in_lag_index - 7'd16);
              rg_r <= GRP_W'((dd >> 3) + 17'd1);
              rd_r <= {2'b0, dd[2:0]};
            end
            state_r <= S_RD0;
          end else begin
            count_r <= count_r + 1'b1;
            zero_r[0] <= {{24{in_sample[15]}}, in_sample};
            sum_r <= sat_add48(sum_r, {{32{in_sample[15]}}, in_sample});
            sqw = 48'(in_sample * in_sample);
            sqs = {2'b0, sq_r} + {17'b0, sqw};
            sq_r <= sqs[63] ? {63{1'b1}} : sqs[62:0];
            g_r <= '0;
            state_r <= S_GRP;
          end
        end
        S_RD0: state_r <= S_RD1;
        S_RD1: begin
          out_product_sum <= rvalid_r ? prod_q : '0;
          out_delayed_sum <= rvalid_r ? dly_q : '0;
          out_direct_sum <= rvalid_r ? direct_r[rg_r] : '0;
          out_lag_valid <= rvalid_r &&
            ((rd_r + fill_r[rg_r]) < ((rg_r == '0) ? 5'd16 : 5'd8));
          out_sample_count <= count_r;
          out_total_sum <= sum_r;
          out_square_sum <= sq_r;
          state_r <= S_OUT;
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        // group entry: zero bin forward, fill count, direct sum
        S_GRP: begin
          zb_r <= zero_r[g_r];
          if (int'(g_r) + 1 < GROUPS)
            zero_r[g_r + 1'b1] <= zero_r[g_r + 1'b1] + zero_r[g_r];
          if ((g_r == '0 || fill_r[g_r - 1'b1] == '0) && fill_r[g_r] != '0)
            fill_r[g_r] <= fill_r[g_r] - 1'b1;
          direct_r[g_r] <= sat_add48(direct_r[g_r],
                                     {{8{zero_r[g_r][39]}}, zero_r[g_r]});
          d_r <= '0;
          state_r <= S_LRD;
        end
        S_LRD: state_r <= S_LWAIT;
        // ring value arrives, mac starts; accumulators at lag d read
        S_LWAIT: begin
          ring_hold_r <= ring_q;
          state_r <= S_LACC;
        end
        S_LACC: begin
          if (d_r == len - 1'b1) begin
            state_r <= S_ROT;
          end else begin
            d_r <= d_r + 1'b1;
            state_r <= S_LRD;
          end
        end
        S_ROT: state_r <= S_ROTW;
        S_ROTW: begin
          if (int'(g_r) + 1 < GROUPS)
            carry_r[g_r + 1'b1] <= carry_r[g_r + 1'b1] + ring_q;
          head_r[g_r] <= newest;
          parity_r[g_r] <= ~parity_r[g_r];
          carry_r[g_r] <= '0;
          zero_r[g_r] <= '0;
          if (!parity_r[g_r] || int'(g_r) + 1 >= GROUPS) state_r <= S_IDLE;
          else begin
            g_r <= g_r + 1'b1;
            state_r <= S_GRP;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
